// ===== hdl/greedy_label_box_placer_assert.svh =====
// Assertion macros for the label box placer checks.
// Each macro expands to one labeled concurrent assertion on clk / arst_n.
`ifndef GREEDY_LABEL_BOX_PLACER_ASSERT_SVH
`define GREEDY_LABEL_BOX_PLACER_ASSERT_SVH

// Same-cycle implication.
`define GLBP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glbp check failed");

// Next-cycle implication.
`define GLBP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glbp check failed");

`endif

// ===== hdl/glbp_pkg.sv =====
// ----------------------------------------------------------------------------
// glbp_pkg
// Shared types, constants and helpers of the label box placer.
// ----------------------------------------------------------------------------
package glbp_pkg;

	localparam int MAX_LABELS = 32;
	localparam int LANE_TRIES = 24;
	localparam int IDX_W      = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
	localparam int CNT_W      = $clog2(MAX_LABELS + 1);
	localparam int LANE_W     = $clog2(LANE_TRIES + 1);

	// internal coordinate width, signed
	localparam int CW = 22;
	localparam int DW = 2 * CW + 1;

	localparam int PAD  = 80;   // 5 px
	localparam int OFFS = 208;  // 13 px
	localparam int GAP  = 64;   // 4 px

	localparam logic [1:0] HOW_LANE   = 2'd0;
	localparam logic [1:0] HOW_GRID   = 2'd1;
	localparam logic [1:0] HOW_FORCED = 2'd2;

	localparam logic CFG_VIEW_W = 1'b0;
	localparam logic CFG_VIEW_H = 1'b1;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [DW-1:0]        dist_t;

	typedef struct packed {
		logic signed [15:0] anchor_x;
		logic signed [15:0] anchor_y;
		logic [13:0]        box_width;
		logic [13:0]        box_height;
		logic [15:0]        label_id;
		logic               last_candidate;
	} cand_t;

	typedef struct packed {
		logic [15:0]        out_label_id;
		logic signed [15:0] out_anchor_x;
		logic signed [15:0] out_anchor_y;
		logic signed [15:0] box_left;
		logic signed [15:0] box_top;
		logic [13:0]        out_width;
		logic [13:0]        out_height;
		logic [1:0]         placed_how;
		logic               last_of_run;
	} place_t;

	// one placed box: corner and size
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [13:0] w;
		logic [13:0] h;
	} box_t;

	function automatic coord_t sx16(logic [15:0] v);
		return {{(CW-16){v[15]}}, v};
	endfunction

	function automatic coord_t zx14(logic [13:0] v);
		return {{(CW-14){1'b0}}, v};
	endfunction

	function automatic coord_t zx15(logic [14:0] v);
		return {{(CW-15){1'b0}}, v};
	endfunction

	// clamp a corner into [PAD, view - size - PAD], lower bound wins
	function automatic coord_t clamp_pos(coord_t p, logic [13:0] size, logic [14:0] view);
		coord_t hi;
		coord_t r;
		hi = zx15(view) - zx14(size) - coord_t'(PAD);
		if (hi < coord_t'(PAD)) hi = coord_t'(PAD);
		r = p;
		if (r < coord_t'(PAD)) r = coord_t'(PAD);
		if (r > hi) r = hi;
		return r;
	endfunction

endpackage

// ===== hdl/glbp_overlap.sv =====
// ----------------------------------------------------------------------------
// glbp_overlap
// Gap-padded rectangle overlap test of a trial box against one placed box.
// ----------------------------------------------------------------------------
module glbp_overlap import glbp_pkg::*; (
	input  coord_t      tx,
	input  coord_t      ty,
	input  logic [13:0] tw,
	input  logic [13:0] th,
	input  box_t        pb,
	output logic        hit
);

	coord_t px, py, pw, ph;

	always_comb begin
		px  = sx16(pb.x);
		py  = sx16(pb.y);
		pw  = zx14(pb.w);
		ph  = zx14(pb.h);
		hit = (tx < px + pw + coord_t'(GAP)) &&
		      (tx + zx14(tw) + coord_t'(GAP) > px) &&
		      (ty < py + ph + coord_t'(GAP)) &&
		      (ty + zx14(th) + coord_t'(GAP) > py);
	end

endmodule

// ===== hdl/glbp_dist.sv =====
// ----------------------------------------------------------------------------
// glbp_dist
// Squared distance dx*dx + dy*dy on one shared multiplier.
// ----------------------------------------------------------------------------
module glbp_dist import glbp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  coord_t dx,
	input  coord_t dy,
	output logic   done,
	output dist_t  sum_sq
);

	logic [1:0]          phase_q;
	logic                done_q;
	coord_t              a_q, b_q, op;
	logic [2*CW-1:0]     prod_q;
	dist_t               acc_q;
	logic signed [2*CW-1:0] sq;

	assign op     = (phase_q == 2'd1) ? a_q : b_q;
	assign sq     = op * op;
	assign done   = done_q;
	assign sum_sq = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				2'd0: if (start) phase_q <= 2'd1;
				2'd1: phase_q <= 2'd2;
				2'd2: phase_q <= 2'd3;
				2'd3: begin
					phase_q <= 2'd0;
					done_q  <= 1'b1;
				end
				default: phase_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == 2'd0 && start) begin
			a_q <= dx;
			b_q <= dy;
		end
		if (phase_q == 2'd1 || phase_q == 2'd2) prod_q <= sq;
		if (phase_q == 2'd2) acc_q <= {1'b0, prod_q};
		if (phase_q == 2'd3) acc_q <= acc_q + {1'b0, prod_q};
	end

endmodule

// ===== hdl/greedy_label_box_placer.sv =====
// ----------------------------------------------------------------------------
// greedy_label_box_placer
// Collects label candidates, sorts them, places boxes without overlap.
// ----------------------------------------------------------------------------
// Use: candidates arrive on the cand channel (valid/ready). Each transfer is
// stored while room remains (MAX_LABELS entries); extra ones are dropped.
// A transfer with last_candidate set starts a layout run over the stored
// set; cand_ready stays low until the run's final placement is handed to the
// output register. Placements leave on the place channel in sorted order
// (anchor y, anchor x, id), one per stored candidate, last_of_run on the
// final one. The viewport registers are to be written through cfg_we only
// while idle; the block itself does not enforce this. A run rank-sorts the
// stored keys one key compare at a time, then takes each label in turn:
// it fetches it and tries lanes, each scanning the placed boxes until one
// overlaps; if every lane overlaps, a grid search visits cells row by row
// and takes the squared distance of each free cell, and if no cell is free
// the label takes the forced fallback before it is emitted. The shared
// overlap comparator and the single multiplier of the distance unit do this work.
// Reset clears counts and the sequencer and loads the default viewport;
// store contents are not cleared. A stalled receiver holds the output
// register, and the run pauses at its next placement until it drains.
// ----------------------------------------------------------------------------
module greedy_label_box_placer import glbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cand_valid,
	output logic        cand_ready,
	input  cand_t       cand,
	output logic        place_valid,
	input  logic        place_ready,
	output place_t      place,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);

	// sequencer codes
	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_R_RDI    = 5'd1;
	localparam logic [4:0] ST_R_LDI    = 5'd2;
	localparam logic [4:0] ST_R_RDJ    = 5'd3;
	localparam logic [4:0] ST_R_CMPJ   = 5'd4;
	localparam logic [4:0] ST_R_WR     = 5'd5;
	localparam logic [4:0] ST_P_RDO    = 5'd6;
	localparam logic [4:0] ST_P_RDC    = 5'd7;
	localparam logic [4:0] ST_P_LDC    = 5'd8;
	localparam logic [4:0] ST_L_TRIAL  = 5'd9;
	localparam logic [4:0] ST_SC_RD    = 5'd10;
	localparam logic [4:0] ST_SC_CMP   = 5'd11;
	localparam logic [4:0] ST_L_NEXT   = 5'd12;
	localparam logic [4:0] ST_G_ROW    = 5'd13;
	localparam logic [4:0] ST_G_CELL   = 5'd14;
	localparam logic [4:0] ST_G_NEXT   = 5'd15;
	localparam logic [4:0] ST_G_DIST   = 5'd16;
	localparam logic [4:0] ST_FALLBACK = 5'd17;
	localparam logic [4:0] ST_EMIT     = 5'd18;

	// ---- stores ----
	logic [31:0]      anchor_store [MAX_LABELS];
	logic [27:0]      size_store   [MAX_LABELS];
	logic [15:0]      id_store     [MAX_LABELS];
	box_t             placed_store [MAX_LABELS];
	logic [IDX_W-1:0] order_store  [MAX_LABELS];

	logic [31:0]      anchor_rd;
	logic [27:0]      size_rd;
	logic [15:0]      id_rd;
	box_t             placed_rd;
	logic [IDX_W-1:0] order_rd;

	// ---- control ----
	logic [4:0]       state_q;
	logic [CNT_W-1:0] loaded_q, pc_q, k_q, ks_q, ri_q, rj_q, rank_q;
	logic [LANE_W-1:0] lane_q;
	logic             mode_grid_q, hit_q, found_q;
	logic [14:0]      vw_q, vh_q;

	// ---- working registers ----
	logic [47:0]      ki_q;
	logic signed [15:0] ax_q, ay_q;
	logic [13:0]      w_q, h_q;
	logic [15:0]      id_q;
	coord_t           off_q, tx_q, ty_q, gx_q, gy_q, bx_q, by_q;
	dist_t            best_q;
	logic [1:0]       how_q;

	logic             place_valid_q;
	place_t           place_q;

	logic [IDX_W-1:0] cand_addr;
	logic             ovl_hit;
	logic             dist_start, dist_done;
	dist_t            dist_val;
	coord_t           lane_h, col_w, ax_c, ay_c, py_lane, dx_c, dy_c;
	logic [47:0]      kj;
	logic             cand_xfer, emit_go;

	assign cand_ready  = (state_q == ST_IDLE);
	assign cand_xfer   = cand_valid && cand_ready;
	assign place_valid = place_valid_q;
	assign place       = place_q;
	assign emit_go     = (state_q == ST_EMIT) && (!place_valid_q || place_ready);

	assign lane_h  = zx14(h_q) + coord_t'(GAP);
	assign col_w   = zx14(w_q) + coord_t'(GAP);
	assign ax_c    = sx16(ax_q);
	assign ay_c    = sx16(ay_q);
	assign py_lane = lane_q[0] ? (ay_c + off_q) : (ay_c - off_q);
	// doubled coordinates keep the box center integral
	assign dx_c    = (gx_q <<< 1) + zx14(w_q) - (ax_c <<< 1);
	assign dy_c    = (gy_q <<< 1) + zx14(h_q) - (ay_c <<< 1);
	assign dist_start = (state_q == ST_G_NEXT) && !hit_q;

	// sort key: sign-flipped y, sign-flipped x, id as one unsigned word
	assign kj = {~anchor_rd[31], anchor_rd[30:16], ~anchor_rd[15], anchor_rd[14:0], id_rd};

	always_comb begin
		unique case (state_q)
			ST_R_RDI: cand_addr = ri_q[IDX_W-1:0];
			ST_R_RDJ: cand_addr = rj_q[IDX_W-1:0];
			default:  cand_addr = order_rd;
		endcase
	end

	// memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (cand_xfer && loaded_q < CNT_W'(MAX_LABELS)) begin
			anchor_store[loaded_q[IDX_W-1:0]] <= {cand.anchor_y, cand.anchor_x};
			size_store[loaded_q[IDX_W-1:0]]   <= {cand.box_height, cand.box_width};
			id_store[loaded_q[IDX_W-1:0]]     <= cand.label_id;
		end
		anchor_rd <= anchor_store[cand_addr];
		size_rd   <= size_store[cand_addr];
		id_rd     <= id_store[cand_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_R_WR) order_store[rank_q[IDX_W-1:0]] <= ri_q[IDX_W-1:0];
		order_rd <= order_store[k_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (emit_go) placed_store[pc_q[IDX_W-1:0]] <= {bx_q[15:0], by_q[15:0], w_q, h_q};
		placed_rd <= placed_store[ks_q[IDX_W-1:0]];
	end

	glbp_overlap u_ovl (
		.tx  (tx_q),
		.ty  (ty_q),
		.tw  (w_q),
		.th  (h_q),
		.pb  (placed_rd),
		.hit (ovl_hit)
	);

	glbp_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.dx     (dx_c),
		.dy     (dy_c),
		.done   (dist_done),
		.sum_sq (dist_val)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q <= 15'd20480;
			vh_q <= 15'd11520;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VIEW_W: vw_q <= cfg_data;
				CFG_VIEW_H: vh_q <= cfg_data;
				default:    vw_q <= vw_q;
			endcase
		end
	end

	// output register valid: set on emit, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_valid_q <= 1'b0;
		end else if (emit_go) begin
			place_valid_q <= 1'b1;
		end else if (place_ready) begin
			place_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			loaded_q      <= '0;
			pc_q          <= '0;
			k_q           <= '0;
			ks_q          <= '0;
			ri_q          <= '0;
			rj_q          <= '0;
			rank_q        <= '0;
			lane_q        <= '0;
			mode_grid_q   <= 1'b0;
			hit_q         <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cand_xfer) begin
						if (loaded_q < CNT_W'(MAX_LABELS)) loaded_q <= loaded_q + 1'b1;
						if (cand.last_candidate) begin
							ri_q    <= '0;
							state_q <= ST_R_RDI;
						end
					end
				end
				// rank sort: position of i = count of keys ahead of it
				ST_R_RDI: state_q <= ST_R_LDI;
				ST_R_LDI: begin
					rj_q    <= '0;
					rank_q  <= '0;
					state_q <= ST_R_RDJ;
				end
				ST_R_RDJ: state_q <= ST_R_CMPJ;
				ST_R_CMPJ: begin
					if (kj < ki_q || (kj == ki_q && rj_q < ri_q)) rank_q <= rank_q + 1'b1;
					if (rj_q + 1'b1 == loaded_q) begin
						state_q <= ST_R_WR;
					end else begin
						rj_q    <= rj_q + 1'b1;
						state_q <= ST_R_RDJ;
					end
				end
				ST_R_WR: begin
					if (ri_q + 1'b1 == loaded_q) begin
						k_q     <= '0;
						pc_q    <= '0;
						state_q <= ST_P_RDO;
					end else begin
						ri_q    <= ri_q + 1'b1;
						state_q <= ST_R_RDI;
					end
				end
				// placement of the k-th label in sorted order
				ST_P_RDO: state_q <= ST_P_RDC;
				ST_P_RDC: state_q <= ST_P_LDC;
				ST_P_LDC: begin
					lane_q  <= '0;
					state_q <= ST_L_TRIAL;
				end
				ST_L_TRIAL: begin
					ks_q        <= '0;
					mode_grid_q <= 1'b0;
					state_q     <= ST_SC_RD;
				end
				// scan the placed boxes against the trial box, stopping at the first overlap
				ST_SC_RD: begin
					if (ks_q == pc_q) begin
						hit_q   <= 1'b0;
						state_q <= mode_grid_q ? ST_G_NEXT : ST_L_NEXT;
					end else begin
						state_q <= ST_SC_CMP;
					end
				end
				ST_SC_CMP: begin
					if (ovl_hit) begin
						hit_q   <= 1'b1;
						state_q <= mode_grid_q ? ST_G_NEXT : ST_L_NEXT;
					end else begin
						ks_q    <= ks_q + 1'b1;
						state_q <= ST_SC_RD;
					end
				end
				ST_L_NEXT: begin
					if (!hit_q) begin
						state_q <= ST_EMIT;
					end else if (lane_q == LANE_W'(LANE_TRIES - 1)) begin
						found_q <= 1'b0;
						state_q <= ST_G_ROW;
					end else begin
						lane_q  <= lane_q + 1'b1;
						state_q <= ST_L_TRIAL;
					end
				end
				ST_G_ROW: begin
					if (gy_q + zx14(h_q) + coord_t'(PAD) <= zx15(vh_q)) begin
						state_q <= ST_G_CELL;
					end else if (found_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_FALLBACK;
					end
				end
				ST_G_CELL: begin
					if (gx_q + zx14(w_q) + coord_t'(PAD) <= zx15(vw_q)) begin
						ks_q        <= '0;
						mode_grid_q <= 1'b1;
						state_q     <= ST_SC_RD;
					end else begin
						state_q <= ST_G_ROW;
					end
				end
				ST_G_NEXT: state_q <= hit_q ? ST_G_CELL : ST_G_DIST;
				ST_G_DIST: begin
					if (dist_done) begin
						if (!found_q || dist_val < best_q) found_q <= 1'b1;
						state_q <= ST_G_CELL;
					end
				end
				ST_FALLBACK: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						if (k_q + 1'b1 == loaded_q) begin
							loaded_q <= '0;
							pc_q     <= '0;
							state_q  <= ST_IDLE;
						end else begin
							pc_q    <= pc_q + 1'b1;
							k_q     <= k_q + 1'b1;
							state_q <= ST_P_RDO;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_R_LDI: ki_q <= kj;
			ST_P_LDC: begin
				ax_q  <= anchor_rd[15:0];
				ay_q  <= anchor_rd[31:16];
				w_q   <= size_rd[13:0];
				h_q   <= size_rd[27:14];
				id_q  <= id_rd;
				off_q <= zx14(size_rd[27:14]) + coord_t'(GAP);
			end
			ST_L_TRIAL: begin
				tx_q <= clamp_pos(ax_c + coord_t'(OFFS), w_q, vw_q);
				ty_q <= clamp_pos(py_lane, h_q, vh_q);
			end
			ST_L_NEXT: begin
				if (!hit_q) begin
					bx_q  <= tx_q;
					by_q  <= ty_q;
					how_q <= HOW_LANE;
				end else if (lane_q[0]) begin
					off_q <= off_q + lane_h;
				end
				gy_q <= coord_t'(PAD);
			end
			ST_G_ROW: begin
				gx_q <= coord_t'(PAD);
				if (found_q) how_q <= HOW_GRID;
			end
			ST_G_CELL: begin
				tx_q <= gx_q;
				ty_q <= gy_q;
				if (gx_q + zx14(w_q) + coord_t'(PAD) > zx15(vw_q)) gy_q <= gy_q + lane_h;
			end
			ST_G_NEXT: if (hit_q) gx_q <= gx_q + col_w;
			ST_G_DIST: begin
				if (dist_done) begin
					if (!found_q || dist_val < best_q) begin
						best_q <= dist_val;
						bx_q   <= gx_q;
						by_q   <= gy_q;
					end
					gx_q <= gx_q + col_w;
				end
			end
			ST_FALLBACK: begin
				bx_q  <= clamp_pos(ax_c + coord_t'(OFFS), w_q, vw_q);
				by_q  <= clamp_pos(ay_c - lane_h, h_q, vh_q);
				how_q <= HOW_FORCED;
			end
			ST_EMIT: begin
				if (emit_go) begin
					place_q.out_label_id <= id_q;
					place_q.out_anchor_x <= ax_q;
					place_q.out_anchor_y <= ay_q;
					place_q.box_left     <= bx_q[15:0];
					place_q.box_top      <= by_q[15:0];
					place_q.out_width    <= w_q;
					place_q.out_height   <= h_q;
					place_q.placed_how   <= how_q;
					place_q.last_of_run  <= (k_q + 1'b1 == loaded_q);
				end
			end
			default: ki_q <= ki_q;
		endcase
	end

endmodule

// ===== hdl/glbp_checker.sv =====
// ----------------------------------------------------------------------------
// glbp_checker
// Port-level checks of the label box placer, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_label_box_placer_assert.svh"

module glbp_checker import glbp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cand_valid,
	input logic        cand_ready,
	input cand_t       cand,
	input logic        place_valid,
	input logic        place_ready,
	input place_t      place,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic [14:0] cfg_data
);

	// a stalled placement holds
	`GLBP_ASSERT_NXT(a_place_hold, place_valid && !place_ready, place_valid && $stable(place))

	// a final candidate starts a run, so the block is busy next cycle
	`GLBP_ASSERT_NXT(a_busy_after_last, cand_valid && cand_ready && cand.last_candidate, !cand_ready)

	// every chosen corner sits at or past the padding
	`GLBP_ASSERT_IMP(a_corner_floor, place_valid, place.box_left >= PAD && place.box_top >= PAD)

endmodule

bind greedy_label_box_placer glbp_checker u_glbp_checker (.*);

// ===== sim/tb_greedy_label_box_placer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_greedy_label_box_placer
// Self-checking bench for the label box placer.
// ----------------------------------------------------------------------------
// A directed table runs first: extreme anchors and sizes, equal sort keys, a
// zero viewport that forces the fallback, a crowded viewport that falls back
// to the grid search, and the largest viewport. Random layout runs follow,
// one of them overflowing the candidate store, under random viewports.
// Placements are checked against the behavioral model here or a typed row.
// ----------------------------------------------------------------------------
module tb_greedy_label_box_placer;
	import glbp_pkg::*;

	localparam int IDLE_LIMIT = 2000000;  // cycles without any transfer
	localparam int DRAIN_GAP  = 20;       // settle time before a register write

	typedef enum logic {ROW_CAND, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e kind;
		logic      cfg_idx;
		int        cfg_val;
		cand_t     c;
		bit        typed;      // expected placement given in the row
		place_t    e;
	} row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cand_valid = 1'b0;
	logic   cand_ready;
	cand_t  cand = '0;
	logic   place_valid;
	logic   place_ready = 1'b0;
	place_t place;
	logic   cfg_we = 1'b0;
	logic   cfg_index = CFG_VIEW_W;
	logic [14:0] cfg_data = '0;

	// layout model state
	longint view_w, view_h;
	logic signed [15:0] st_ax [MAX_LABELS];
	logic signed [15:0] st_ay [MAX_LABELS];
	logic [13:0] st_w [MAX_LABELS];
	logic [13:0] st_h [MAX_LABELS];
	logic [15:0] st_id [MAX_LABELS];
	int          n_loaded;

	place_t placements_due [$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     tx_no_gaps = 1'b0;    // sender runs without gaps
	bit     rx_no_gaps = 1'b0;    // receiver takes every cycle
	bit     rx_hold_req = 1'b0;   // receiver holds off once for a long stretch

	row_t   rows [$];

	greedy_label_box_placer uut (
		.clk(clk), .arst_n(arst_n),
		.cand_valid(cand_valid), .cand_ready(cand_ready), .cand(cand),
		.place_valid(place_valid), .place_ready(place_ready), .place(place),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------ model
	function automatic longint clamp_corner(longint p, longint size, longint view);
		longint hi;
		hi = view - size - PAD;
		if (hi < PAD) hi = PAD;
		if (p < PAD) p = PAD;
		if (p > hi) p = hi;
		return p;
	endfunction

	function automatic bit before_in_order(int a, int b);
		if (st_ay[a] != st_ay[b]) return st_ay[a] < st_ay[b];
		if (st_ax[a] != st_ax[b]) return st_ax[a] < st_ax[b];
		return st_id[a] < st_id[b];
	endfunction

	// take one accepted candidate; on the last one lay out the stored set
	task automatic layout_accept(cand_t c);
		int     order [MAX_LABELS];
		longint bx_q [MAX_LABELS];
		longint by_q [MAX_LABELS];
		longint bw_q [MAX_LABELS];
		longint bh_q [MAX_LABELS];
		int     n, j;
		longint ax, ay, w, h, lane_h, bx, by, x, y, py, best, dx, dy, d;
		logic [1:0] how;
		bit     found, hit;
		place_t r;
		if (n_loaded < MAX_LABELS) begin
			st_ax[n_loaded] = c.anchor_x;
			st_ay[n_loaded] = c.anchor_y;
			st_w[n_loaded]  = c.box_width;
			st_h[n_loaded]  = c.box_height;
			st_id[n_loaded] = c.label_id;
			n_loaded++;
		end
		if (!c.last_candidate) return;
		n = n_loaded;
		// stable insertion sort
		for (int i = 0; i < n; i++) begin
			j = i;
			while (j > 0 && before_in_order(i, order[j-1])) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int i = 0; i < n; i++) begin
			ax = longint'($signed(st_ax[order[i]]));
			ay = longint'($signed(st_ay[order[i]]));
			w = st_w[order[i]];
			h = st_h[order[i]];
			lane_h = h + GAP;
			found = 1'b0;
			bx = 0;
			by = 0;
			how = HOW_FORCED;
			for (int lane = 0; lane < LANE_TRIES && !found; lane++) begin
				py = (lane % 2 == 0) ? ay - (lane / 2 + 1) * lane_h
				                     : ay + (lane / 2 + 1) * lane_h;
				x = clamp_corner(ax + OFFS, w, view_w);
				y = clamp_corner(py, h, view_h);
				hit = 1'b0;
				for (int k = 0; k < i; k++)
					if (x < bx_q[k] + bw_q[k] + GAP && x + w + GAP > bx_q[k] &&
					    y < by_q[k] + bh_q[k] + GAP && y + h + GAP > by_q[k])
						hit = 1'b1;
				if (!hit) begin
					found = 1'b1; bx = x; by = y; how = HOW_LANE;
				end
			end
			if (!found) begin
				best = 0;
				for (y = PAD; y + h + PAD <= view_h; y += lane_h)
					for (x = PAD; x + w + PAD <= view_w; x += w + GAP) begin
						hit = 1'b0;
						for (int k = 0; k < i; k++)
							if (x < bx_q[k] + bw_q[k] + GAP && x + w + GAP > bx_q[k] &&
							    y < by_q[k] + bh_q[k] + GAP && y + h + GAP > by_q[k])
								hit = 1'b1;
						if (!hit) begin
							dx = 2 * x + w - 2 * ax;
							dy = 2 * y + h - 2 * ay;
							d = dx * dx + dy * dy;
							if (!found || d < best) begin
								best = d; bx = x; by = y; found = 1'b1; how = HOW_GRID;
							end
						end
					end
			end
			if (!found) begin
				bx = clamp_corner(ax + OFFS, w, view_w);
				by = clamp_corner(ay - lane_h, h, view_h);
				how = HOW_FORCED;
			end
			// stored corners are 16 bit, as in the block
			bx_q[i] = longint'($signed(bx[15:0]));
			by_q[i] = longint'($signed(by[15:0]));
			bw_q[i] = w;
			bh_q[i] = h;
			r.out_label_id = st_id[order[i]];
			r.out_anchor_x = st_ax[order[i]];
			r.out_anchor_y = st_ay[order[i]];
			r.box_left     = bx[15:0];
			r.box_top      = by[15:0];
			r.out_width    = w[13:0];
			r.out_height   = h[13:0];
			r.placed_how   = how;
			r.last_of_run  = (i + 1 == n);
			placements_due.insert(placements_due.size(), r);
		end
		n_loaded = 0;
	endtask

	// ---------------------------------------------------------------- checker
	// Signals are read in the active region of the edge, before any
	// nonblocking update lands, so these are the values of the transfer.
	always @(posedge clk) begin
		place_t e;
		bit bad;
		if (arst_n && place_valid && place_ready) begin
			if (placements_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected placement %p", $realtime, place);
			end else begin
				e = placements_due.pop_front();
				bad = (place.out_label_id !== e.out_label_id) ||
				      (place.out_anchor_x !== e.out_anchor_x) ||
				      (place.out_anchor_y !== e.out_anchor_y) ||
				      (place.box_left     !== e.box_left) ||
				      (place.box_top      !== e.box_top) ||
				      (place.out_width    !== e.out_width) ||
				      (place.out_height   !== e.out_height) ||
				      (place.placed_how   !== e.placed_how) ||
				      (place.last_of_run  !== e.last_of_run);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: placement mismatch\n  exp %p\n  got %p",
						         $realtime, e, place);
				end
			end
		end
	end

	// watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if ((cand_valid && cand_ready) || (place_valid && place_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_greedy_label_box_placer: done, errors");
			$finish;
		end
	end

	// --------------------------------------------------------------- receiver
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				gap = 3000;           // long stall so the block backs up
				rx_hold_req = 1'b0;
			end else
				gap = rx_no_gaps ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				place_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			place_ready <= 1'b1;
			do @(posedge clk); while (!(place_valid && place_ready));
		end
	end

	// ----------------------------------------------------------------- sender
	task automatic send_candidate(cand_t c);
		int gap;
		gap = tx_no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			cand_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cand <= c;
		cand_valid <= 1'b1;
		do @(posedge clk); while (!cand_ready);
		layout_accept(c);
	endtask

	// drain, settle, then write one viewport register
	task automatic write_view(logic idx, int val);
		cand_valid <= 1'b0;
		while (placements_due.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[14:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_VIEW_W) view_w = val[14:0];
		else view_h = val[14:0];
	endtask

	function automatic void add_row(row_t r);
		rows.insert(rows.size(), r);
	endfunction

	function automatic row_t crow(int ax, int ay, int w, int h, int id, bit last);
		row_t r;
		r.kind = ROW_CAND;
		r.cfg_idx = CFG_VIEW_W;
		r.cfg_val = 0;
		r.c = '{ax[15:0], ay[15:0], w[13:0], h[13:0], id[15:0], last};
		r.typed = 1'b0;
		r.e = '0;
		return r;
	endfunction

	function automatic row_t cfg_row(logic idx, int val);
		row_t r;
		r = crow(0, 0, 0, 0, 0, 1'b0);
		r.kind = ROW_CFG;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	function automatic row_t typed_row(int ax, int ay, int w, int h, int id,
	                                   int bx, int by);
		row_t r;
		r = crow(ax, ay, w, h, id, 1'b1);
		r.typed = 1'b1;
		r.e = '{id[15:0], ax[15:0], ay[15:0], bx[15:0], by[15:0],
		        w[13:0], h[13:0], HOW_LANE, 1'b1};
		return r;
	endfunction

	// random candidate; big_boxes keeps the grid coarse in large viewports
	function automatic cand_t rand_cand(bit big_boxes, bit last);
		cand_t c;
		c.anchor_x = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		c.anchor_y = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3000));
		if (big_boxes) begin
			c.box_width  = 14'($urandom_range(4000, 16383));
			c.box_height = 14'($urandom_range(4000, 16383));
		end else if ($urandom_range(0, 7) == 0) begin
			c.box_width  = 14'($urandom);
			c.box_height = 14'($urandom);
		end else begin
			c.box_width  = 14'($urandom_range(150, 900));
			c.box_height = 14'($urandom_range(150, 900));
		end
		c.label_id = 16'($urandom);
		c.last_candidate = last;
		return c;
	endfunction

	// ------------------------------------------------------------------- main
	initial begin
		int  vw, vh, n, random_items, phase;
		bit  big;
		view_w = 20480;
		view_h = 11520;
		n_loaded = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; corners typed where they follow from clamping alone
		add_row(typed_row(0, 0, 0, 0, 0, 208, 80));
		add_row(typed_row(32767, 32767, 16383, 16383, 16'hFFFF, 4017, 80));
		add_row(typed_row(-32768, -32768, 0, 0, 0, 80, 80));
		// same anchor five times: lanes alternate, equal ids keep load order
		add_row(crow(1600, 1600, 320, 160, 7, 1'b0));
		add_row(crow(1600, 1600, 320, 160, 7, 1'b0));
		add_row(crow(1600, 1600, 320, 160, 3, 1'b0));
		add_row(crow(1600, 1600, 320, 160, 9, 1'b0));
		add_row(crow(1600, 1600, 320, 160, 5, 1'b1));
		// zero viewport: everything sits on the padding, grid empty
		add_row(cfg_row(CFG_VIEW_W, 0));
		add_row(cfg_row(CFG_VIEW_H, 0));
		add_row(crow(100, 100, 16, 16, 1, 1'b0));
		add_row(crow(100, 100, 16, 16, 2, 1'b1));
		// crowded viewport: lanes clamp onto two spots, third box goes to grid
		add_row(cfg_row(CFG_VIEW_W, 1600));
		add_row(cfg_row(CFG_VIEW_H, 1600));
		add_row(crow(400, 800, 200, 400, 10, 1'b0));
		add_row(crow(400, 800, 200, 400, 11, 1'b0));
		add_row(crow(400, 800, 200, 400, 12, 1'b0));
		add_row(crow(400, 800, 200, 400, 13, 1'b1));
		// largest viewport
		add_row(cfg_row(CFG_VIEW_W, 32767));
		add_row(cfg_row(CFG_VIEW_H, 32767));
		add_row(crow(32767, -32768, 16383, 16383, 16'hABCD, 1'b0));
		add_row(crow(-32768, 32767, 16383, 16383, 16'h5432, 1'b1));

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CFG)
				write_view(rows[i].cfg_idx, rows[i].cfg_val);
			else begin
				send_candidate(rows[i].c);
				if (rows[i].typed)
					placements_due[placements_due.size() - 1] = rows[i].e;
			end
		end

		// random phases: a viewport setting, then a few back-to-back runs
		random_items = 0;
		phase = 0;
		while (random_items < 140) begin
			case ($urandom_range(0, 5))
				0: begin vw = 32767; vh = 32767; end
				1: begin vw = 0;     vh = $urandom_range(0, 2500); end
				default: begin vw = $urandom_range(300, 2500); vh = $urandom_range(300, 2500); end
			endcase
			big = (vw > 2500 || vh > 2500);
			write_view(CFG_VIEW_W, vw);
			write_view(CFG_VIEW_H, vh);
			tx_no_gaps = ($urandom_range(0, 3) == 0);
			rx_no_gaps = ($urandom_range(0, 3) == 0);
			for (int run = 0; run < 3; run++) begin
				if (phase == 1 && run == 0) begin
					// overflow: the store fills, the rest is dropped, the
					// dropped last candidate still starts the layout
					n = MAX_LABELS + 3;
					big = 1'b1;
				end else
					n = $urandom_range(1, 6);
				if (phase == 2 && run == 0) rx_hold_req = 1'b1;
				for (int k = 0; k < n; k++)
					send_candidate(rand_cand(big, k == n - 1));
				random_items += n;
			end
			phase++;
		end
		cand_valid <= 1'b0;

		while (placements_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("tb_greedy_label_box_placer: done, clean");
		else
			$display("tb_greedy_label_box_placer: done, errors");
		$finish;
	end

endmodule

// ===== greedy_label_box_placer.f =====
+incdir+hdl
hdl/glbp_pkg.sv
hdl/glbp_overlap.sv
hdl/glbp_dist.sv
hdl/greedy_label_box_placer.sv
hdl/glbp_checker.sv
sim/tb_greedy_label_box_placer.sv
